// ===== design/lru_key_value_cache_macros.svh =====
// assertion macros for the lru key/value cache
// no dependencies; included by the top level
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH
// implication checked on every clock edge outside reset
`define LKV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked also during reset
`define LKV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== design/lkv_pkg.sv =====
// shared constants and types for the lru key/value cache
// no dependencies
package lkv_pkg;
   localparam int unsigned DefMaxEntries = 64;
   localparam int unsigned KeyWidth = 32;
   localparam int unsigned ValWidth = 32;
   localparam int unsigned CapWidth = 7;
   localparam logic ActGet = 1'b0;
   localparam logic ActSet = 1'b1;
   localparam logic [ValWidth-1:0] MissValue = '1;
   localparam logic [0:0] RegCapacity = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic lookup;     // load request, compare keys
      logic update;     // apply the update for the loaded request
      logic evict;      // evict least recent entry
   } lkv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_set;
      logic hit;
      logic need_evict; // count at or over capacity
   } lkv_status_type;
endpackage

// ===== design/lkv_ctrl.sv =====
// controller state machine for the lru key/value cache
// depends on lkv_pkg
module lkv_ctrl
   import lkv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_fire,
   input  logic           rsp_busy,
   input  lkv_status_type status,
   output lkv_cmd_type    cmd,
   output logic           req_ready,
   output logic           rsp_load
);
   typedef enum logic [1:0] {IDLE, COMPARE, EVICT} state_type;
   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.lookup = 1'b1;
               state_in = COMPARE;
            end
         end
         COMPARE: begin
            if (!status.is_set) begin
               if (!rsp_busy) begin
                  cmd.update = 1'b1;
                  rsp_load = 1'b1;
                  state_in = IDLE;
               end
            end else if (!status.hit && status.need_evict) begin
               state_in = EVICT;
            end else begin
               cmd.update = 1'b1;
               state_in = IDLE;
            end
         end
         EVICT: begin
            if (status.need_evict) cmd.evict = 1'b1;
            else begin
               cmd.update = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== design/lkv_datapath.sv =====
// entry array, key compare and recency ranks for the lru key/value cache
// depends on lkv_pkg
module lkv_datapath
   import lkv_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = DefMaxEntries
) (
   input  logic                clock,
   input  logic                reset,
   input  lkv_cmd_type         cmd,
   input  logic                req_action,
   input  logic [KeyWidth-1:0] req_key,
   input  logic [ValWidth-1:0] req_value,
   input  logic [CapWidth-1:0] capacity,
   output lkv_status_type      status,
   output logic                get_hit,
   output logic [ValWidth-1:0] get_value
);
   localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CmpW = (CntW > CapWidth) ? CntW : CapWidth;

   logic [KeyWidth-1:0] key_ff   [MAX_ENTRIES];
   logic [ValWidth-1:0] val_ff   [MAX_ENTRIES];
   logic [IdxW-1:0]     rank_ff  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [CntW-1:0]     count_ff;
   logic                act_ff;
   logic [KeyWidth-1:0] rkey_ff;
   logic [ValWidth-1:0] rval_ff;
   logic [MAX_ENTRIES-1:0] match_ff;

   // effective capacity, clamped to one and to the depth
   logic [CmpW-1:0] cap_eff, cnt_ext;
   always_comb begin
      cap_eff = CmpW'(capacity);
      if (cap_eff == '0) cap_eff = CmpW'(1);
      if (cap_eff > CmpW'(MAX_ENTRIES)) cap_eff = CmpW'(MAX_ENTRIES);
      cnt_ext = CmpW'(count_ff);
   end

   // hit slot, free slot and least recent slot
   logic             hit_any;
   logic [IdxW-1:0]  hit_idx, free_idx, lru_idx;
   logic [IdxW-1:0]  hit_rank;
   always_comb begin
      hit_any  = |match_ff;
      hit_idx  = '0;
      free_idx = '0;
      lru_idx  = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = IdxW'(i);
         if (!valid_ff[i]) free_idx = IdxW'(i);
         if (valid_ff[i] &&
             ((CntW+1)'(rank_ff[i]) == (CntW+1)'(count_ff) - 1'b1))
            lru_idx = IdxW'(i);
      end
      hit_rank = rank_ff[hit_idx];
   end

   assign status.is_set     = act_ff;
   assign status.hit        = hit_any;
   assign status.need_evict = (cnt_ext >= cap_eff) && (count_ff != '0);

   // request capture, key compare, and entry updates
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         act_ff  <= req_action;
         rkey_ff <= req_key;
         rval_ff <= req_value;
         for (int i = 0; i < MAX_ENTRIES; i++)
            match_ff[i] <= valid_ff[i] && (key_ff[i] == req_key);
      end
      if (cmd.update) begin
         if (act_ff == ActSet && hit_any) begin
            val_ff[hit_idx] <= rval_ff;
         end else if (act_ff == ActSet) begin
            for (int i = 0; i < MAX_ENTRIES; i++)
               if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + 1'b1;
            key_ff[free_idx]  <= rkey_ff;
            val_ff[free_idx]  <= rval_ff;
            rank_ff[free_idx] <= '0;
         end else if (hit_any) begin
            for (int i = 0; i < MAX_ENTRIES; i++)
               if (valid_ff[i] && rank_ff[i] < hit_rank) rank_ff[i] <= rank_ff[i] + 1'b1;
            rank_ff[hit_idx] <= '0;
         end
      end
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.evict) begin
         valid_ff[lru_idx] <= 1'b0;
         count_ff <= count_ff - 1'b1;
      end else if (cmd.update && act_ff == ActSet && !hit_any) begin
         valid_ff[free_idx] <= 1'b1;
         count_ff <= count_ff + 1'b1;
      end
   end

   assign get_hit   = hit_any;
   assign get_value = hit_any ? val_ff[hit_idx] : MissValue;
endmodule

// ===== design/lru_key_value_cache.sv =====
// top level of the lru key/value cache: stream ports, csr, controller and datapath
// depends on lkv_pkg, lkv_ctrl, lkv_datapath and the macros header
//
//  port group | dir | beat
//  req_       | in  | tuser action, tdata {write_value, lookup_key}
//  rsp_       | out | tuser hit, tdata read_value
//  csr_       | in  | apb write/read of capacity_in_use at address 0
//
// a get and a set run idle then compare; a set that misses at capacity also passes through evict;
// the key compare is registered, then the rank update follows in compare, or in evict when evicting.
// synchronous reset clears all entries; capacity returns to 64.
// a get waits in compare while the output register still holds an untaken beat.
`include "lru_key_value_cache_macros.svh"
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = DefMaxEntries
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // lookup_key[31:0], write_value[63:32]
   input  logic          req_tuser,   // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // read_value[31:0]
   output logic          rsp_tuser,   // hit
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [0:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   logic [CapWidth-1:0] cap_ff;
   lkv_cmd_type    cmd;
   lkv_status_type status;
   logic rsp_load, get_hit, req_fire;
   logic [ValWidth-1:0] get_value;

   // csr register; paddr holds byte address bit 2 only
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegCapacity) ? {25'b0, cap_ff} : 32'b0;
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CapWidth'(64);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegCapacity)
         cap_ff <= csr_pwdata[CapWidth-1:0];
   end

   assign req_fire = req_tvalid && req_tready;

   lkv_ctrl u_ctrl (
      .clock, .reset, .req_fire,
      .rsp_busy(rsp_tvalid && !rsp_tready),
      .status, .cmd, .req_ready(req_tready), .rsp_load
   );

   lkv_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock, .reset, .cmd,
      .req_action(req_tuser), .req_key(req_tdata[31:0]), .req_value(req_tdata[63:32]),
      .capacity(cap_ff), .status, .get_hit, .get_value
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (rsp_load) rsp_tvalid <= 1'b1;
      else if (rsp_tready) rsp_tvalid <= 1'b0;
      if (rsp_load) begin
         rsp_tdata <= get_value;
         rsp_tuser <= get_hit;
      end
   end

   `LKV_ASSERT(a_load_free, clock, reset, rsp_load |-> !(rsp_tvalid && !rsp_tready), "result overwritten")
   `LKV_ASSERT(a_miss_val, clock, reset, (rsp_tvalid && !rsp_tuser) |-> rsp_tdata == MissValue, "miss value wrong")
   `LKV_ASSERT_ALWAYS(a_rst, clock, $past(reset) |-> !rsp_tvalid, "valid after reset")
endmodule
